FILE: design/sbfd_pkg.sv
// sbfd_pkg: shared constants for the seven-bit frame decoder
// link byte codes, fill state encoding and output bus layout
// no dependencies
`default_nettype none

package sbfd_pkg;

	// default frame size limit in payload bytes
	localparam int DEF_MAX_FRAME_BYTES = 256;

	// top two bits of a link byte
	localparam logic [1:0] TOP_START = 2'b10;
	localparam logic [1:0] TOP_END   = 2'b11;

	// bit counts held in the partial byte, none held
	localparam logic [3:0] FILL_NONE = 4'd8;

	// output bus layout
	localparam int IDX_W   = 8;
	localparam int VAL_W   = 8;
	localparam int LEN_W   = 9;
	localparam int TDATA_W = 32;
	localparam int TUSER_W = 2;

	localparam int USER_BYTE_VALID  = 0;
	localparam int USER_FRAME_BEGIN = 1;

endpackage

`default_nettype wire

FILE: design/seven_bit_frame_decoder.sv
// Bytes from the link enter on s_* at up to one transfer per clock and are
// unpacked into payload bytes; every accepted byte gives exactly one result
// transfer on m_* from the result register. While m_tready is high the rate is
// one byte per cycle: the frame state (fill count, partial byte, byte count) is
// updated by a single pass of shift and compare logic between the input
// register and the result register. A start byte (10xxxxxx) opens a frame and
// flags frame_begin, data bytes (0xxxxxxx) add seven bits, an end byte
// (11xxxxxx) adds up to six closing bits and raises tlast with the frame length.
// Frames longer than MAX_FRAME_BYTES, and ends that find one stray bit, close
// without tlast. Bytes outside a frame give an all-zero result.
//
// seven_bit_frame_decoder: top level, frame unpacking state and stream ports
// depends on sbfd_pkg
`default_nettype none

module seven_bit_frame_decoder #(
	parameter int MAX_FRAME_BYTES = sbfd_pkg::DEF_MAX_FRAME_BYTES
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [7:0]                       s_tdata,  // rx_byte
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// byte_index[7:0], byte_value[15:8], frame_length[24:16], zero[31:25]
	output logic [sbfd_pkg::TDATA_W-1:0]     m_tdata,
	output logic [sbfd_pkg::TUSER_W-1:0]     m_tuser,  // byte_valid[0], frame_begin[1]
	output logic                             m_tlast   // frame_done
);
	import sbfd_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

	// input stage
	logic [7:0] rx_s1;
	logic       valid_s1;
	logic       advance;

	// frame state
	logic             in_frame_q, in_frame_n;
	logic [3:0]       filled_q, filled_n;
	logic [7:0]       partial_q, partial_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             ovf_q, ovf_n;

	// result
	logic             bv, begin_f, done_f;
	logic [CNT_W-1:0] idx_c, len_c;
	logic [7:0]       val_c;
	logic [31:0]      idx_w, len_w;
	logic [7:0]       data8, end8;
	logic             ok;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_s1 <= s_tdata;
		end
	end

	always_comb begin
		data8      = {1'b0, rx_s1[6:0]};
		end8       = {2'b00, rx_s1[5:0]};
		in_frame_n = in_frame_q;
		filled_n   = filled_q;
		partial_n  = partial_q;
		cnt_n      = cnt_q;
		ovf_n      = ovf_q;
		bv         = 1'b0;
		begin_f    = 1'b0;
		done_f     = 1'b0;
		idx_c      = '0;
		len_c      = '0;
		val_c      = '0;
		ok         = 1'b0;
		priority if (rx_s1[7:6] == TOP_START) begin
			in_frame_n = 1'b1;
			ovf_n      = 1'b0;
			cnt_n      = '0;
			partial_n  = {rx_s1[5:0], 2'b00};
			filled_n   = 4'd6;
			begin_f    = 1'b1;
		end else if (!in_frame_q) begin
			// outside a frame
		end else if (rx_s1[7:6] == TOP_END) begin
			ok = !ovf_q;
			if (ok && filled_q != FILL_NONE) begin
				if (filled_q < 4'd2 || filled_q > 4'd7) begin
					ok = 1'b0;
				end else if (cnt_q >= CNT_MAX) begin
					ok = 1'b0;
				end else begin
					bv    = 1'b1;
					idx_c = cnt_q;
					val_c = partial_q | (end8 >> (filled_q - 4'd2));
					len_c = cnt_q + 1'b1;
				end
			end else begin
				len_c = cnt_q;
			end
			if (ok) begin
				done_f = 1'b1;
			end else begin
				bv    = 1'b0;
				idx_c = '0;
				val_c = '0;
				len_c = '0;
			end
			in_frame_n = 1'b0;
			filled_n   = FILL_NONE;
			partial_n  = '0;
			cnt_n      = '0;
			ovf_n      = 1'b0;
		end else if (!ovf_q) begin
			if (filled_q >= FILL_NONE || filled_q == 4'd0) begin
				partial_n = data8 << 1;
				filled_n  = 4'd7;
			end else if (cnt_q >= CNT_MAX) begin
				ovf_n = 1'b1;
			end else begin
				bv    = 1'b1;
				idx_c = cnt_q;
				val_c = partial_q | (data8 >> (filled_q - 4'd1));
				cnt_n = cnt_q + 1'b1;
				if (filled_q == 4'd1) begin
					partial_n = '0;
					filled_n  = FILL_NONE;
				end else begin
					partial_n = data8 << (4'd9 - filled_q);
					filled_n  = filled_q - 4'd1;
				end
			end
		end
		idx_w = 32'(idx_c);
		len_w = 32'(len_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			filled_q   <= FILL_NONE;
			partial_q  <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			if (advance) begin
				in_frame_q <= in_frame_n;
				filled_q   <= filled_n;
				partial_q  <= partial_n;
				cnt_q      <= cnt_n;
				ovf_q      <= ovf_n;
			end
			if (advance) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {{(TDATA_W - IDX_W - VAL_W - LEN_W){1'b0}},
				len_w[LEN_W-1:0], val_c, idx_w[IDX_W-1:0]};
			m_tuser[USER_BYTE_VALID]  <= bv;
			m_tuser[USER_FRAME_BEGIN] <= begin_f;
			m_tlast <= done_f;
		end
	end

endmodule

`default_nettype wire

FILE: design/sbfd_checker.sv
// sbfd_checker: port-level checks on the seven-bit frame decoder results
// depends on sbfd_pkg; bound to seven_bit_frame_decoder below
`default_nettype none

module sbfd_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [sbfd_pkg::TDATA_W-1:0]  m_tdata,
	input wire [sbfd_pkg::TUSER_W-1:0]  m_tuser,
	input wire                          m_tlast
);
	import sbfd_pkg::*;

	// an empty result register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

	// stalled result transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// a start byte never completes a payload byte or a frame
	a_begin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_FRAME_BEGIN] |-> !m_tuser[USER_BYTE_VALID] && !m_tlast)
		else $error("frame begin with byte or done");

	// index and value are zero without a payload byte
	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[USER_BYTE_VALID] |-> m_tdata[IDX_W+VAL_W-1:0] == '0)
		else $error("byte fields set without byte_valid");

	// length is zero unless the frame finished
	a_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[TDATA_W-1:IDX_W+VAL_W] == '0)
		else $error("frame length set without frame done");

endmodule

bind seven_bit_frame_decoder sbfd_checker u_sbfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/seven_bit_frame_decoder_tb.sv
// seven_bit_frame_decoder_tb: self-checking bench for the seven-bit frame decoder
// drives link bytes on s_*, predicts each result transfer and checks it on m_*
// depends on sbfd_pkg and seven_bit_frame_decoder
`timescale 1ns / 1ps

module seven_bit_frame_decoder_tb;
	import sbfd_pkg::*;

	localparam int MAX_BYTES      = DEF_MAX_FRAME_BYTES;
	localparam int RANDOM_ITEMS   = 540;
	localparam int CALM_TAIL      = 150;
	localparam int LONG_HOLD      = 120;
	localparam int HOLD_AFTER     = 400;
	localparam int DRAIN_WAIT     = 10;
	localparam int TIMEOUT_CYCLES = 300000;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_index;
		logic [7:0] byte_value;
		logic       frame_begin;
		logic       frame_done;
		logic [8:0] frame_length;
	} frame_result_t;

	typedef struct {
		logic [7:0] rx_byte;
		bit         drain_first;
	} link_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'h00;  // rx_byte
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// byte_index[7:0], byte_value[15:8], frame_length[24:16], zero[31:25]
	logic [TDATA_W-1:0]  m_tdata;
	logic [TUSER_W-1:0]  m_tuser;  // byte_valid[0], frame_begin[1]
	logic                m_tlast;  // frame_done

	seven_bit_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	link_item_t    link_bytes[$];
	frame_result_t expected_results[$];
	int            errors = 0;
	int            results_seen = 0;
	int            cycle_count = 0;
	int            idle_left = 0;
	int            stall_left = 0;
	int            hold_left = 0;
	bit            long_hold_done = 1'b0;
	bit            s_took = 1'b0;

	// decoder state mirror
	bit         in_frame = 1'b0;
	int         fill_bits = FILL_NONE;
	logic [7:0] part_byte = 8'h00;
	int         byte_count = 0;
	bit         overrun = 1'b0;

	function automatic frame_result_t unpack_link_byte(logic [7:0] b);
		frame_result_t r;
		logic [7:0]    d;
		bit            ok;
		r = '0;
		d = {1'b0, b[6:0]};
		if (b[7:6] == TOP_START) begin
			in_frame = 1'b1;
			overrun = 1'b0;
			byte_count = 0;
			part_byte = {b[5:0], 2'b00};
			fill_bits = 6;
			r.frame_begin = 1'b1;
		end else if (!in_frame) begin
			r = '0;
		end else if (b[7:6] == TOP_END) begin
			ok = !overrun;
			if (ok && fill_bits != FILL_NONE) begin
				if (fill_bits < 2) begin
					ok = 1'b0;
				end else if (byte_count >= MAX_BYTES) begin
					ok = 1'b0;
				end else begin
					r.byte_valid = 1'b1;
					r.byte_index = byte_count[7:0];
					r.byte_value = part_byte | ({2'b00, b[5:0]} >> (fill_bits - 2));
					byte_count++;
				end
			end
			if (ok) begin
				r.frame_done = 1'b1;
				r.frame_length = byte_count[8:0];
			end else begin
				r = '0;
			end
			in_frame = 1'b0;
			fill_bits = FILL_NONE;
			part_byte = 8'h00;
			byte_count = 0;
			overrun = 1'b0;
		end else if (!overrun) begin
			if (fill_bits >= FILL_NONE || fill_bits == 0) begin
				part_byte = {d[6:0], 1'b0};
				fill_bits = 7;
			end else if (byte_count >= MAX_BYTES) begin
				overrun = 1'b1;
			end else begin
				r.byte_valid = 1'b1;
				r.byte_index = byte_count[7:0];
				r.byte_value = part_byte | (d >> (fill_bits - 1));
				byte_count++;
				if (fill_bits == 1) begin
					part_byte = 8'h00;
					fill_bits = FILL_NONE;
				end else begin
					part_byte = 8'(d << (9 - fill_bits));
					fill_bits--;
				end
			end
		end
		return r;
	endfunction

	task automatic push_link(logic [7:0] b, bit drain = 1'b0);
		link_item_t it;
		it.rx_byte = b;
		it.drain_first = drain;
		link_bytes.push_back(it);
	endtask

	// start, n data bytes with random payload, optional end
	task automatic push_frame(int n, bit with_end, bit drain = 1'b0);
		push_link({TOP_START, 6'($urandom)}, drain);
		repeat (n) push_link({1'b0, 7'($urandom)});
		if (with_end)
			push_link({TOP_END, 6'($urandom)});
	endtask

	// scoreboard: predict on input transfer, check on result transfer
	always @(posedge clk) begin
		frame_result_t want;
		frame_result_t got;
		s_took = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				s_took = 1'b1;
				void'(link_bytes.pop_front());
				expected_results.push_back(unpack_link_byte(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.byte_valid   = m_tuser[USER_BYTE_VALID];
				got.byte_index   = m_tdata[7:0];
				got.byte_value   = m_tdata[15:8];
				got.frame_begin  = m_tuser[USER_FRAME_BEGIN];
				got.frame_done   = m_tlast;
				got.frame_length = m_tdata[24:16];
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transfer: tdata %h tuser %b tlast %b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					want = expected_results.pop_front();
					if (got !== want || m_tdata[31:25] !== '0) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch at result %0d: exp valid %b idx %0d val %h ",
								"begin %b done %b len %0d / got valid %b idx %0d val %h ",
								"begin %b done %b len %0d pad %h"}, results_seen,
								want.byte_valid, want.byte_index, want.byte_value,
								want.frame_begin, want.frame_done, want.frame_length,
								got.byte_valid, got.byte_index, got.byte_value,
								got.frame_begin, got.frame_done, got.frame_length,
								m_tdata[31:25]);
					end
				end
			end
		end
	end

	// link byte driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_took)) begin
			if (idle_left > 0) begin
				idle_left--;
				s_tvalid <= 1'b0;
			end else if (link_bytes.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (link_bytes[0].drain_first && expected_results.size() != 0) begin
				s_tvalid <= 1'b0;
			end else if (link_bytes.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
				idle_left = $urandom_range(1, 8) - 1;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= link_bytes[0].rx_byte;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (link_bytes.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int count;
		int pick;
		int n;
		// bytes outside a frame give an all-zero result
		push_link(8'h00);
		push_link(8'hFF);
		push_link(8'h7F);
		// shortest frames with extreme payload bits
		push_link(8'h80);
		push_link(8'hFF);
		push_link(8'hBF);
		push_link(8'hC0);
		// six data bytes land on a byte boundary, end gives no byte
		push_link(8'hAA);
		push_link(8'h00);
		push_link(8'h7F);
		push_link(8'h55);
		push_link(8'h2A);
		push_link(8'h7F);
		push_link(8'h00);
		push_link(8'hE5);
		// one stray bit left at the end drops the frame
		push_link(8'h9C);
		repeat (5) push_link({1'b0, 7'($urandom)});
		push_link(8'hDB);
		// a new start abandons the open frame
		push_link(8'h81);
		push_link(8'h33);
		push_link(8'hBE);
		push_link(8'hF3);
		// frame limit: exactly full, full before the end, overflowing data
		push_frame(291, 1'b1, 1'b1);
		push_frame(292, 1'b1);
		push_frame($urandom_range(293, 300), 1'b1);
		count = 0;
		while (count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			n = $urandom_range(0, 12);
			if (pick < 70) begin
				push_frame(n, 1'b1, count > 250 && count < 270 && pick < 5);
				count += n + 2;
			end else if (pick < 80) begin
				push_frame(n, 1'b0);
				count += n + 1;
			end else if (pick < 88) begin
				n = 5 + 8 * $urandom_range(0, 1);
				push_frame(n, 1'b1);
				count += n + 2;
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) push_link(8'($urandom));
				count += n;
			end
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (link_bytes.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/sbfd_pkg.sv
design/seven_bit_frame_decoder.sv
design/sbfd_checker.sv
tb/seven_bit_frame_decoder_tb.sv
